// ===== sv/dcm_pkg.sv =====
// diverging colormap package: position types, palette levels and blend helpers
// used by dcm_scale, dcm_blend and the top level; depends on nothing
`default_nettype none

package dcm_pkg;

  // widths of the sample, scale, fixed-point position, sums and colour channels
  localparam int unsigned SampleW = 16;
  localparam int unsigned InvMaxW = 24;
  localparam int unsigned BandW   = 15;
  localparam int unsigned PosW    = 12;
  localparam int unsigned ProdW   = SampleW + InvMaxW + 1;
  localparam int unsigned ScaleSh = 17;
  localparam int unsigned SumW    = 20;
  localparam int unsigned ColW    = 8;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indices
  localparam logic [CfgIdxW-1:0] CFG_INV_MAX   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_BAND = 2'd1;

  // register reset values
  localparam logic [InvMaxW-1:0] INV_MAX_RST   = 24'd65536;
  localparam logic [BandW-1:0]   ZERO_BAND_RST = 15'd0;

  // highest palette segment
  localparam logic [2:0] SEG_LAST = 3'd5;

  // colour levels of the palette stops
  typedef enum logic [1:0] {
    LVL_ZERO = 2'd0,
    LVL_HALF = 2'd1,
    LVL_FULL = 2'd2
  } lvl_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  // position of one item inside the palette
  typedef struct packed {
    logic             black;
    logic [2:0]       seg;
    logic [PosW-1:0]  frac;
  } pos_t;

  // level of one channel at a palette stop: blue, sky, cyan, white, yellow, orange, red
  function automatic lvl_e stop_level(logic [2:0] idx, chan_e ch);
    lvl_e lvl;
    lvl = LVL_ZERO;
    case (ch)
      CH_RED: begin
        lvl = (idx >= 3'd3 && idx <= 3'd6) ? LVL_FULL : LVL_ZERO;
      end
      CH_GREEN: begin
        case (idx)
          3'd1, 3'd5: lvl = LVL_HALF;
          3'd2, 3'd3, 3'd4: lvl = LVL_FULL;
          default: lvl = LVL_ZERO;
        endcase
      end
      CH_BLUE: begin
        lvl = (idx <= 3'd3) ? LVL_FULL : LVL_ZERO;
      end
      default: lvl = LVL_ZERO;
    endcase
    return lvl;
  endfunction

  // level times weight, by shifts: 255*x or 128*x or zero
  function automatic logic [SumW-1:0] lvl_mul(lvl_e lvl, logic [PosW:0] x);
    logic [SumW-1:0] xe;
    logic [SumW-1:0] r;
    xe = {{(SumW-PosW-1){1'b0}}, x};
    case (lvl)
      LVL_FULL: r = (xe << 8) - xe;
      LVL_HALF: r = xe << 7;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dcm_sample_if.sv =====
// sample channel: valid/ready handshake carrying one signed field sample
// depends on dcm_pkg
`default_nettype none

interface dcm_sample_if
  import dcm_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SampleW-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== sv/dcm_rgb_if.sv =====
// colour channel: valid/ready handshake carrying one 8-bit rgb item
// depends on dcm_pkg
`default_nettype none

interface dcm_rgb_if
  import dcm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ColW-1:0]  red;
  logic [ColW-1:0]  green;
  logic [ColW-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== sv/dcm_scale.sv =====
// first two pipeline stages: sample times inv_max and zero band test, then offset and
// clamp to a Q0.12 position and split it into palette segment and fraction; uses dcm_pkg
`default_nettype none

module dcm_scale
  import dcm_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [InvMaxW-1:0]         inv_max_i,
  input  wire logic [BandW-1:0]           zero_band_i,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic signed [SampleW-1:0]  sample_i,
  output      logic                       pos_valid_o,
  input  wire logic                       pos_ready_i,
  output      pos_t                       pos_o
);

  localparam logic signed [ProdW:0] PosOffset = (ProdW+1)'(2048) <<< ScaleSh;

  logic                       v1_q, v2_q;
  logic                       rdy1, rdy2;
  logic signed [ProdW-1:0]    prod_d, prod_q;
  logic                       black_d, black_q;
  logic [SampleW:0]           mag;
  logic signed [ProdW:0]      t;
  logic [ProdW-ScaleSh:0]     quo;
  logic [PosW-1:0]            s;
  logic [PosW+2:0]            six;
  pos_t                       pos_d, pos_q;

  // stage readiness, bubbles collapse
  assign rdy2       = !v2_q || pos_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: product and zero band test
  assign prod_d  = sample_i * $signed({1'b0, inv_max_i});
  assign mag     = sample_i[SampleW-1] ? (SampleW+1)'(-{sample_i[SampleW-1], sample_i})
                                       : {1'b0, sample_i};
  assign black_d = (zero_band_i != '0) && (mag < {{(SampleW+1-BandW){1'b0}}, zero_band_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      prod_q  <= prod_d;
      black_q <= black_d;
    end
  end

  // stage 2: offset, clamp, times six, split
  assign t   = {prod_q[ProdW-1], prod_q} + PosOffset;
  assign quo = t[ProdW:ScaleSh];

  always_comb begin
    if (t[ProdW]) begin
      s = '0;
    end else if (|quo[ProdW-ScaleSh:PosW]) begin
      s = '1;
    end else begin
      s = quo[PosW-1:0];
    end
  end

  assign six         = {1'b0, s, 2'b00} + {2'b00, s, 1'b0};
  assign pos_d.black = black_q;
  assign pos_d.seg   = six[PosW+2:PosW];
  assign pos_d.frac  = six[PosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      pos_q <= pos_d;
    end
  end

  assign pos_valid_o = v2_q;
  assign pos_o       = pos_q;

`ifndef SYNTHESIS
  // the clamp keeps the segment inside the palette
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> pos_q.seg <= SEG_LAST)
    else $error("palette segment past the last stop");

  // a stalled position item stays put
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !pos_ready_i |=> v2_q && $stable(pos_q))
    else $error("position item changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== sv/dcm_blend.sv =====
// last two pipeline stages: weighted sum of the two palette stops per
// channel, then rounding and the black band into the output register; uses dcm_pkg
`default_nettype none

module dcm_blend
  import dcm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  pos_valid_i,
  output      logic  pos_ready_o,
  input  wire pos_t  pos_i,
  dcm_rgb_if.source  rgb_o
);

  localparam logic [SumW-1:0] Half = SumW'(2048);

  logic                  v3_q, v4_q;
  logic                  rdy3, rdy4;
  logic [PosW:0]         wlo, whi;
  logic [2:0]            seg_hi;
  logic [SumW-1:0]       sum_d [3];
  logic [SumW-1:0]       sum_q [3];
  logic                  black_q;
  logic [ColW-1:0]       col_d [3];
  logic [ColW-1:0]       col_q [3];

  // stage readiness, bubbles collapse
  assign rdy4        = !v4_q || rgb_o.ready;
  assign rdy3        = !v3_q || rdy4;
  assign pos_ready_o = rdy3;

  // stage 3: weights and per-channel blend sums
  assign whi    = {1'b0, pos_i.frac};
  assign wlo    = (PosW+1)'(1 << PosW) - whi;
  assign seg_hi = pos_i.seg + 3'd1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = lvl_mul(stop_level(pos_i.seg, chan_e'(2'(k))), wlo)
               + lvl_mul(stop_level(seg_hi, chan_e'(2'(k))), whi) + Half;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= pos_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && pos_valid_i) begin
      sum_q   <= sum_d;
      black_q <= pos_i.black;
    end
  end

  // stage 4: drop the fraction, black band wins
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      col_d[k] = black_q ? '0 : sum_q[k][PosW+ColW-1:PosW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      col_q <= col_d;
    end
  end

  assign rgb_o.valid = v4_q;
  assign rgb_o.red   = col_q[0];
  assign rgb_o.green = col_q[1];
  assign rgb_o.blue  = col_q[2];

`ifndef SYNTHESIS
  // an item inside the zero band comes out black
  a_black_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && rdy4 && black_q |=> v4_q && rgb_o.red == '0 && rgb_o.green == '0
                                && rgb_o.blue == '0)
    else $error("zero band item not shown black");
`endif

endmodule

`default_nettype wire

// ===== sv/diverging_colormap_pixel.sv =====
// top level of the diverging colormap: configuration registers and the
// four-stage pipeline; depends on dcm_pkg, dcm_sample_if, dcm_rgb_if, dcm_scale, dcm_blend
`default_nettype none

// Maps one signed 16-bit sample per item to an 8-bit rgb colour through a
// seven-stop diverging palette (blue, sky, cyan, white, yellow, orange, red).
// Throughput is one item per clock while the output takes items; an accepted
// item passes through multiply, clamp and split, stop blend and rounding into
// the output register before it stands on the output channel. Each stage
// stalls only when it holds an item that the next cannot take, so gaps close
// up under back-pressure. Register 0 (inv_max, Q8.16) scales the sample,
// register 1 (zero_band) shows samples of smaller magnitude in black when
// nonzero; write them only while no item is in flight.

module diverging_colormap_pixel
  import dcm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [InvMaxW-1:0]  cfg_data_i,
  dcm_sample_if.sink               sample_i,
  dcm_rgb_if.source                rgb_o
);

  logic [InvMaxW-1:0]  inv_max_q;
  logic [BandW-1:0]    zero_band_q;
  logic                pos_valid;
  logic                pos_ready;
  pos_t                pos;

  // configuration registers, unknown indices ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_max_q   <= INV_MAX_RST;
      zero_band_q <= ZERO_BAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INV_MAX:   inv_max_q   <= cfg_data_i;
        CFG_ZERO_BAND: zero_band_q <= cfg_data_i[BandW-1:0];
        default: ;
      endcase
    end
  end

  // scale and position stages
  dcm_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .inv_max_i   (inv_max_q),
    .zero_band_i (zero_band_q),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .sample_i    (sample_i.sample),
    .pos_valid_o (pos_valid),
    .pos_ready_i (pos_ready),
    .pos_o       (pos)
  );

  // blend and output stages
  dcm_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pos_valid_i (pos_valid),
    .pos_ready_o (pos_ready),
    .pos_i       (pos),
    .rgb_o       (rgb_o)
  );

endmodule

`default_nettype wire

// ===== tb/diverging_colormap_pixel_tb.sv =====
// self-checking testbench for diverging_colormap_pixel: random and corner samples with
// random idling on both channels, each colour checked against a local predictor
// depends on dcm_pkg, dcm_sample_if, dcm_rgb_if and the diverging_colormap_pixel rtl

module diverging_colormap_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dcm_pkg::*;

  // register indices that decode to nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  localparam int MAX_WAIT        = 6;
  localparam int LONG_HOLD       = 80;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int TIMEOUT_NS      = 2_000_000;

  // palette stops, blue to red, each as {red, green, blue}
  localparam logic [6:0][2:0][ColW-1:0] STOP_RGB = {
    24'hFF0000, 24'hFF8000, 24'hFFFF00, 24'hFFFFFF, 24'h00FFFF, 24'h0080FF, 24'h0000FF
  };
  localparam logic signed [47:0] MID_OFFSET = 48'sd2048 <<< ScaleSh;
  localparam logic [PosW-1:0]    POS_TOP    = '1;

  typedef struct packed {
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
  } rgb_t;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]         cfg_idx    = '0;
  logic [InvMaxW-1:0]         cfg_data   = '0;
  logic                       drv_valid  = 1'b0;
  logic signed [SampleW-1:0]  drv_sample = '0;
  logic                       rgb_ready  = 1'b0;

  // register contents as the block should hold them
  logic [InvMaxW-1:0] gain_setting = INV_MAX_RST;
  logic [BandW-1:0]   band_setting = ZERO_BAND_RST;

  logic signed [SampleW-1:0] pending_samples[$];
  rgb_t                      expected_colours[$];
  rgb_t                      due_colour;
  rgb_t                      want_colour;

  logic steady_gaps = 1'b0;
  int   gap_left;
  int   stall_left;
  int   out_stall;
  int   hold_left;
  int   hold_requests = 0;
  int   hold_served;
  int   mismatches    = 0;
  int   samples_sent  = 0;
  int   black_items   = 0;
  int   settings_used = 0;

  logic signed [SampleW-1:0] corner_samples [14] = '{
    16'sh8000, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd4096, -16'sd4097,
    16'sd4094, 16'sd4095, 16'sh5555, 16'shAAAA, -16'sd2732, -16'sd2730, 16'sd2730
  };
  logic signed [SampleW-1:0] band_samples [6] = '{
    16'sd99, 16'sd100, -16'sd99, -16'sd100, -16'sd101, 16'sd0
  };
  logic signed [SampleW-1:0] wide_band_samples [4] = '{
    16'sh8000, 16'sd32767, -16'sd32767, 16'sd32766
  };

  dcm_sample_if sample_ch ();
  dcm_rgb_if    rgb_ch ();

  assign sample_ch.valid  = drv_valid;
  assign sample_ch.sample = drv_sample;
  assign rgb_ch.ready     = rgb_ready;

  diverging_colormap_pixel u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (sample_ch),
    .rgb_o      (rgb_ch)
  );

  initial forever #5 clk_i = ~clk_i;

  // colour that one sample should map to under the given registers
  function automatic rgb_t map_to_colour(logic signed [SampleW-1:0] smp,
                                         logic [InvMaxW-1:0] gain, logic [BandW-1:0] band);
    logic signed [47:0]    scaled;
    logic [47:0]           whole;
    logic [PosW-1:0]       pos;
    logic [PosW+2:0]       six_pos;
    logic [2:0]            seg;
    logic [PosW-1:0]       frac;
    logic [SampleW:0]      mag;
    logic [20:0]           mix;
    logic [2:0][ColW-1:0]  chans;
    rgb_t                  c;
    // position in q0.12, floored and clamped
    scaled = smp * $signed({1'b0, gain}) + MID_OFFSET;
    if (scaled < 0) begin
      pos = '0;
    end else begin
      whole = scaled >> ScaleSh;
      pos = (whole > POS_TOP) ? POS_TOP : whole[PosW-1:0];
    end
    six_pos = pos * 3'd6;
    seg     = six_pos[PosW+2:PosW];
    frac    = six_pos[PosW-1:0];
    mag     = smp[SampleW-1] ? (17'd0 - {1'b1, smp}) : {1'b0, smp};
    // black band around zero, otherwise blend of the two stops
    if (band != '0 && mag < band) begin
      chans = '0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        mix = STOP_RGB[seg][k] * (13'd4096 - frac) + STOP_RGB[seg + 3'd1][k] * frac + 21'd2048;
        chans[k] = mix[PosW+ColW-1:PosW];
      end
    end
    c.red   = chans[2];
    c.green = chans[1];
    c.blue  = chans[0];
    return c;
  endfunction

  function automatic int draw_wait();
    return steady_gaps ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // random sample, weighted towards the band edge, the extremes and saturation
  function automatic logic signed [SampleW-1:0] pick_sample(logic [InvMaxW-1:0] gain,
                                                           logic [BandW-1:0] band);
    int span;
    int lim;
    int v;
    span = (gain == '0) ? 32767 : int'((1 << 28) / gain);
    if (span > 32767) span = 32767;
    lim = (band == '0) ? 64 : int'(band) + 2;
    case ($urandom_range(0, 9))
      5, 6: v = int'($urandom_range(0, 2 * lim)) - lim;
      7: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      8, 9: begin
        v = span - 8 + int'($urandom_range(0, 16));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SampleW-1:0];
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [InvMaxW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INV_MAX:   gain_setting = data;
      CFG_ZERO_BAND: band_setting = data[BandW-1:0];
      default: ;
    endcase
  endtask

  // checked between edges so the driver's updates have settled
  task automatic wait_idle();
    while (pending_samples.size() != 0 || drv_valid || expected_colours.size() != 0)
      @(negedge clk_i);
  endtask

  // sample driver: holds an item until taken, random gap before the next
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      drv_sample <= '0;
      gap_left   <= 0;
    end else begin
      if (drv_valid && sample_ch.ready) begin
        due_colour = map_to_colour(drv_sample, gain_setting, band_setting);
        expected_colours.push_back(due_colour);
        samples_sent++;
        if (due_colour == '0) black_items++;
      end
      if (drv_valid && !sample_ch.ready) begin
        // item still waiting
      end else if (gap_left != 0) begin
        drv_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        drv_valid  <= 1'b1;
        drv_sample <= pending_samples.pop_front();
        gap_left   <= draw_wait();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // colour monitor: checks each item, then stalls at random or for a long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_ready   <= 1'b0;
      stall_left  <= 0;
      hold_left   <= 0;
      hold_served <= 0;
    end else begin
      if (rgb_ready && rgb_ch.valid) begin
        if (expected_colours.size() == 0) begin
          $error("colour item with no sample outstanding: red %0d green %0d blue %0d",
                 rgb_ch.red, rgb_ch.green, rgb_ch.blue);
          mismatches++;
        end else begin
          want_colour = expected_colours.pop_front();
          if (rgb_ch.red !== want_colour.red) begin
            $error("red: expected %0d, got %0d", want_colour.red, rgb_ch.red);
            mismatches++;
          end
          if (rgb_ch.green !== want_colour.green) begin
            $error("green: expected %0d, got %0d", want_colour.green, rgb_ch.green);
            mismatches++;
          end
          if (rgb_ch.blue !== want_colour.blue) begin
            $error("blue: expected %0d, got %0d", want_colour.blue, rgb_ch.blue);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        rgb_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
        hold_served <= hold_served + 1;
        hold_left   <= LONG_HOLD;
        rgb_ready   <= 1'b0;
      end else if (rgb_ready && rgb_ch.valid) begin
        out_stall = draw_wait();
        if (out_stall == 0) begin
          rgb_ready <= 1'b1;
        end else begin
          rgb_ready  <= 1'b0;
          stall_left <= out_stall - 1;
        end
      end else if (stall_left != 0) begin
        rgb_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        rgb_ready <= 1'b1;
      end
    end
  end

  // stimulus: corner samples, then random phases over several register settings
  initial begin : stimulus
    logic [InvMaxW-1:0] gain;
    logic [BandW-1:0]   band;
    logic [31:0]        junk;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: extremes, saturation and segment boundaries
    @(negedge clk_i);
    foreach (corner_samples[i]) pending_samples.push_back(corner_samples[i]);
    wait_idle();
    settings_used++;

    // narrow black band, samples either side of its edge
    write_reg(CFG_ZERO_BAND, 24'd100);
    @(negedge clk_i);
    foreach (band_samples[i]) pending_samples.push_back(band_samples[i]);
    wait_idle();

    // widest band, and writes to unused indices that must change nothing
    write_reg(CFG_ZERO_BAND, 24'd32767);
    write_reg(CFG_SPARE_A, 24'd0);
    write_reg(CFG_SPARE_B, 24'd5);
    @(negedge clk_i);
    foreach (wide_band_samples[i]) pending_samples.push_back(wide_band_samples[i]);
    wait_idle();
    settings_used += 2;

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: begin gain = INV_MAX_RST;  band = ZERO_BAND_RST; end
        1: begin gain = '0;           band = '0;            end
        2: begin gain = '1;           band = '1;            end
        3: begin gain = 24'd1;        band = 15'd1;         end
        4: begin gain = 24'd524288;   band = 15'd300;       end
        5: begin gain = 24'd3000;     band = '0;            end
        default: begin
          gain = InvMaxW'($urandom_range(0, 24'hFFFFFF));
          band = BandW'($urandom_range(0, 2000));
        end
      endcase
      junk = $urandom;
      write_reg(CFG_INV_MAX, gain);
      write_reg(CFG_ZERO_BAND, {junk[InvMaxW-BandW-1:0], band});
      @(negedge clk_i);
      steady_gaps = (phase == 1 || phase == 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        pending_samples.push_back(pick_sample(gain, band));
      // hold the output back so the pipeline fills and stalls its input
      if (phase == 2 || phase == 5) hold_requests++;
      wait_idle();
      settings_used++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d samples mapped under %0d register settings, %0d of them in the black band",
             samples_sent, settings_used, black_items);
    $display("output held back for %0d long stretches, %0d field mismatches",
             hold_served, mismatches);
    if (mismatches == 0 && expected_colours.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
